### sv/tcaof_pkg.sv
`default_nettype none
package tcaof_pkg;

    localparam int TAG_W       = 16;
    localparam int OUT_STAMP_W = 32;

    typedef enum logic [1:0] {
        ACT_PUSH     = 2'd0,
        ACT_POP_ANY  = 2'd1,
        ACT_POP_C0   = 2'd2,
        ACT_POP_C1   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_PUSHED = 2'd0,
        ST_POPPED = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        t_action           action;
        logic              item_class;
        logic [TAG_W-1:0]  item_tag;
    } t_in_item;

    typedef struct packed {
        t_status                 status;
        logic                    out_class;
        logic [TAG_W-1:0]        out_tag;
        logic [OUT_STAMP_W-1:0]  out_stamp;
    } t_out_item;

endpackage
`default_nettype wire

### sv/two_class_age_ordered_fifo.sv
// Two-class age-ordered FIFO.
// Input channel (i_in_valid / o_in_stall / i_in) carries one action per
// transaction: push a tagged item of class 0 or 1, pop the oldest item of
// either class, or pop the head of one class. Every input transaction gives
// exactly one output transaction (o_out_valid / i_out_stall / o_out) holding
// a status (pushed, popped, empty, full) and the item's class, tag and stamp.
// Each class lives in its own single-port-per-side memory of QUEUE_DEPTH
// entries; pushes are stamped from a STAMP_WIDTH-bit arrival counter that
// advances on each successful push, and a pop of either class picks the
// head with the older stamp (wrap-aware). The head read completes at the
// accepting edge; the EXEC state then updates pointers and registers the
// result. No new transaction is taken until the previous one has passed the
// memory read step and the pointer update step. An input is taken while a
// previous result still waits at the output; the update step holds until the
// output register is free, so a stalled receiver backs up into o_in_stall.
// Reset clears pointers, counts, the arrival counter and the output valid;
// memory contents are not cleared and are never used before written.
`default_nettype none
module two_class_age_ordered_fifo #(
    parameter int QUEUE_DEPTH = 16,
    parameter int STAMP_WIDTH = 32
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_stall,
    input  wire tcaof_pkg::t_in_item i_in,
    output logic                   o_out_valid,
    input  wire                    i_out_stall,
    output tcaof_pkg::t_out_item   o_out
);
    import tcaof_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ENT_W = TAG_W + STAMP_WIDTH;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    logic [ENT_W-1:0] mem0 [QUEUE_DEPTH];
    logic [ENT_W-1:0] mem1 [QUEUE_DEPTH];
    logic [ENT_W-1:0] r_rd0, r_rd1;

    t_state            r_state, n_state;
    t_in_item          r_item;
    logic [PTR_W-1:0]  r_head0, n_head0, r_tail0, n_tail0;
    logic [PTR_W-1:0]  r_head1, n_head1, r_tail1, n_tail1;
    logic [CNT_W-1:0]  r_cnt0, n_cnt0, r_cnt1, n_cnt1;
    logic [STAMP_WIDTH-1:0] r_arrival, n_arrival;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    logic              we0, we1;
    logic [ENT_W-1:0]  wdata;
    logic              take_in, out_free;
    logic              sel1, do_pop, pop_cls;
    logic [STAMP_WIDTH-1:0] stamp0, stamp1, stamp_diff, pop_stamp;
    logic [TAG_W-1:0]  pop_tag;
    logic [63:0]       stamp_ext;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        ptr_next = (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    assign o_in_stall  = (r_state != S_IDLE);
    assign take_in     = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign stamp0     = r_rd0[STAMP_WIDTH-1:0];
    assign stamp1     = r_rd1[STAMP_WIDTH-1:0];
    assign stamp_diff = stamp0 - stamp1;
    assign wdata      = {r_item.item_tag, r_arrival};

    always_ff @(posedge i_clk) begin
        if (we0) begin
            mem0[r_tail0] <= wdata;
        end
        if (we1) begin
            mem1[r_tail1] <= wdata;
        end
        r_rd0 <= mem0[r_head0];
        r_rd1 <= mem1[r_head1];
        if (take_in) begin
            r_item <= i_in;
        end
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head0     <= '0;
            r_tail0     <= '0;
            r_cnt0      <= '0;
            r_head1     <= '0;
            r_tail1     <= '0;
            r_cnt1      <= '0;
            r_arrival   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head0     <= n_head0;
            r_tail0     <= n_tail0;
            r_cnt0      <= n_cnt0;
            r_head1     <= n_head1;
            r_tail1     <= n_tail1;
            r_cnt1      <= n_cnt1;
            r_arrival   <= n_arrival;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_head0     = r_head0;
        n_tail0     = r_tail0;
        n_cnt0      = r_cnt0;
        n_head1     = r_head1;
        n_tail1     = r_tail1;
        n_cnt1      = r_cnt1;
        n_arrival   = r_arrival;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        we0         = 1'b0;
        we1         = 1'b0;
        sel1        = 1'b0;
        do_pop      = 1'b0;
        pop_cls     = 1'b0;
        pop_stamp   = '0;
        pop_tag     = '0;
        stamp_ext   = '0;

        case (r_state)
            S_IDLE: begin
                if (take_in) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    case (r_item.action)
                        ACT_PUSH: begin
                            sel1 = r_item.item_class;
                        end
                        ACT_POP_C0: begin
                            sel1 = 1'b0;
                        end
                        ACT_POP_C1: begin
                            sel1 = 1'b1;
                        end
                        ACT_POP_ANY: begin
                            if (r_cnt0 == '0) begin
                                sel1 = 1'b1;
                            end else if (r_cnt1 == '0) begin
                                sel1 = 1'b0;
                            end else begin
                                sel1 = !stamp_diff[STAMP_WIDTH-1];
                            end
                        end
                        default: begin
                            sel1 = 1'b0;
                        end
                    endcase

                    if (r_item.action == ACT_PUSH) begin
                        n_out.out_class = r_item.item_class;
                        n_out.out_tag   = r_item.item_tag;
                        if ((sel1 ? r_cnt1 : r_cnt0) == CNT_FULL) begin
                            n_out.status    = ST_FULL;
                            n_out.out_stamp = '0;
                        end else begin
                            n_out.status    = ST_PUSHED;
                            stamp_ext       = 64'(r_arrival);
                            n_out.out_stamp = stamp_ext[OUT_STAMP_W-1:0];
                            n_arrival       = r_arrival + 1'b1;
                            if (sel1) begin
                                we1     = 1'b1;
                                n_tail1 = ptr_next(r_tail1);
                                n_cnt1  = r_cnt1 + 1'b1;
                            end else begin
                                we0     = 1'b1;
                                n_tail0 = ptr_next(r_tail0);
                                n_cnt0  = r_cnt0 + 1'b1;
                            end
                        end
                    end else begin
                        do_pop = (sel1 ? r_cnt1 : r_cnt0) != '0;
                        if (do_pop) begin
                            pop_cls   = sel1;
                            pop_tag   = sel1 ? r_rd1[ENT_W-1:STAMP_WIDTH]
                                             : r_rd0[ENT_W-1:STAMP_WIDTH];
                            pop_stamp = sel1 ? stamp1 : stamp0;
                            if (sel1) begin
                                n_head1 = ptr_next(r_head1);
                                n_cnt1  = r_cnt1 - 1'b1;
                            end else begin
                                n_head0 = ptr_next(r_head0);
                                n_cnt0  = r_cnt0 - 1'b1;
                            end
                        end
                        stamp_ext       = 64'(pop_stamp);
                        n_out.status    = do_pop ? ST_POPPED : ST_EMPTY;
                        n_out.out_class = pop_cls;
                        n_out.out_tag   = pop_tag;
                        n_out.out_stamp = stamp_ext[OUT_STAMP_W-1:0];
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire
